FILE: hdl/assert_macros.svh
// Assertion macros shared by the height-to-hue color RTL.
// Depends on nothing; files that assert include it after the timescale line.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is high.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define ASSERT_CLK_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: hdl/hthc_pkg.sv
// Package for the height-to-hue color unit: register indexes, reset values,
// item kinds, hue sector codes and the fixed error color. No dependencies.
`timescale 1ns / 1ps

package hthc_pkg;

   localparam int COLOR_BITS_DEFAULT = 8;
   localparam int DIV_STEPS          = 16;

   // Register indexes on the csr port
   localparam logic [1:0] CSR_LOW_HEIGHT  = 2'd0;
   localparam logic [1:0] CSR_HIGH_HEIGHT = 2'd1;
   localparam logic [1:0] CSR_HUE_SCALE   = 2'd2;

   localparam logic [31:0] LOW_HEIGHT_RESET  = 32'hFFFF_0000;
   localparam logic [31:0] HIGH_HEIGHT_RESET = 32'h0001_0000;
   localparam logic [15:0] HUE_SCALE_RESET   = 16'd26214;

   typedef enum logic [1:0] {
      KIND_DIVIDE,
      KIND_ZERO,
      KIND_FULL,
      KIND_RANGE_ERROR
   } kind_type;

   // Hue sectors: full channel first, ramping channel second
   localparam logic [2:0] SECTOR_RED_GREEN  = 3'd0;
   localparam logic [2:0] SECTOR_GREEN_RED  = 3'd1;
   localparam logic [2:0] SECTOR_GREEN_BLUE = 3'd2;
   localparam logic [2:0] SECTOR_BLUE_GREEN = 3'd3;
   localparam logic [2:0] SECTOR_BLUE_RED   = 3'd4;
   localparam logic [2:0] SECTOR_RED_BLUE   = 3'd5;

   localparam logic [7:0] CHANNEL_FULL = 8'd255;
   localparam logic [7:0] CHANNEL_ZERO = 8'd0;
   localparam logic [7:0] CHANNEL_HALF = 8'd128;

endpackage

FILE: hdl/height_to_hue_color_unit.sv
// Height-to-hue color unit: normalizes a Q16.16 height, maps it to a hue and
// converts the hue to 8-bit RGB. Depends on hthc_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

// The unit takes one height transaction per clock while rsp_ready is high or
// an empty stage remains, and returns one color per height, in order. It has
// sixteen restoring divider stages (one quotient bit per stage) plus two
// front stages for range and clamp and four back stages for the hue multiply,
// sector split, ramp level and channel scaling. Each stage holds its item when
// the stage after it is full and cannot move on, so bubbles close up and a
// stalled result does not block input while empty stages remain. A zero height
// range returns pale red (255, 128, 128) with rsp_range_error set. Write the
// csr registers only while the unit holds no transaction.
module height_to_hue_color_unit
   import hthc_pkg::*;
#(
   parameter int COLOR_BITS = COLOR_BITS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [31:0] req_height,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_red,
   output logic [7:0]  rsp_green,
   output logic [7:0]  rsp_blue,
   output logic        rsp_range_error,
   input  logic        csr_write_enable,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_write_data
);

   localparam int STG_RANGE  = 0;
   localparam int STG_DIV0   = 1;
   localparam int STG_MULT   = STG_DIV0 + DIV_STEPS + 1;
   localparam int STG_SECTOR = STG_MULT + 1;
   localparam int STG_LEVEL  = STG_SECTOR + 1;
   localparam int STG_COLOR  = STG_LEVEL + 1;
   localparam int NSTAGE     = STG_COLOR + 1;
   localparam int PW         = COLOR_BITS + 9;

   // ---------------- configuration registers ----------------
   logic [31:0] low_height_ff;
   logic [31:0] high_height_ff;
   logic [15:0] hue_scale_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         low_height_ff  <= LOW_HEIGHT_RESET;
         high_height_ff <= HIGH_HEIGHT_RESET;
         hue_scale_ff   <= HUE_SCALE_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_LOW_HEIGHT:  low_height_ff  <= csr_write_data;
            CSR_HIGH_HEIGHT: high_height_ff <= csr_write_data;
            CSR_HUE_SCALE:   hue_scale_ff   <= csr_write_data[15:0];
            default: ;
         endcase
      end
   end

   // ---------------- stage handshake ----------------
   logic [NSTAGE-1:0] stage_valid_ff;
   logic [NSTAGE-1:0] stage_load;

   assign stage_load[NSTAGE-1] = !stage_valid_ff[NSTAGE-1] || rsp_ready;

   for (genvar i = 0; i < NSTAGE - 1; i++) begin : g_load
      assign stage_load[i] = !stage_valid_ff[i] || stage_load[i+1];
   end

   for (genvar i = 0; i < NSTAGE; i++) begin : g_valid
      logic valid_in;
      if (i == 0) begin : g_first
         assign valid_in = req_valid;
      end else begin : g_next
         assign valid_in = stage_valid_ff[i-1];
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            stage_valid_ff[i] <= 1'b0;
         end else if (stage_load[i]) begin
            stage_valid_ff[i] <= valid_in;
         end
      end
   end

   assign req_ready = stage_load[0];
   assign rsp_valid = stage_valid_ff[NSTAGE-1];

   // ---------------- range: n = height - low, d = high - low ----------------
   logic signed [33:0] num_ff, num_in;
   logic signed [33:0] den_ff, den_in;

   assign num_in = {{2{req_height[31]}}, req_height}
                 - {{2{low_height_ff[31]}}, low_height_ff};
   assign den_in = {{2{high_height_ff[31]}}, high_height_ff}
                 - {{2{low_height_ff[31]}}, low_height_ff};

   always_ff @(posedge clock) begin
      if (stage_load[STG_RANGE]) begin
         num_ff <= num_in;
         den_ff <= den_in;
      end
   end

   // ---------------- sign fix and clamp, divider entry ----------------
   kind_type          div_kind_ff [0:DIV_STEPS];
   logic [31:0]       div_rem_ff  [0:DIV_STEPS];
   logic [31:0]       div_den_ff  [0:DIV_STEPS];
   logic [15:0]       div_quo_ff  [0:DIV_STEPS];

   logic signed [33:0] num_abs;
   logic signed [33:0] den_abs;
   kind_type           kind_in;

   always_comb begin
      if (den_ff < 0) begin
         num_abs = -num_ff;
         den_abs = -den_ff;
      end else begin
         num_abs = num_ff;
         den_abs = den_ff;
      end
      if (den_ff == 0) begin
         kind_in = KIND_RANGE_ERROR;
      end else if (num_abs <= 0) begin
         kind_in = KIND_ZERO;
      end else if (num_abs >= den_abs) begin
         kind_in = KIND_FULL;
      end else begin
         kind_in = KIND_DIVIDE;
      end
   end

   always_ff @(posedge clock) begin
      if (stage_load[STG_DIV0]) begin
         div_kind_ff[0] <= kind_in;
         div_rem_ff[0]  <= num_abs[31:0];
         div_den_ff[0]  <= den_abs[31:0];
         div_quo_ff[0]  <= 16'd0;
      end
   end

   // ---------------- restoring divider, one quotient bit per stage ----------------
   for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
      logic [33:0] trial;
      logic        fits;
      logic [31:0] rem_in;

      assign trial  = {1'b0, div_rem_ff[k], 1'b0} - {2'b00, div_den_ff[k]};
      assign fits   = !trial[33];
      assign rem_in = fits ? trial[31:0] : {div_rem_ff[k][30:0], 1'b0};

      always_ff @(posedge clock) begin
         if (stage_load[STG_DIV0 + 1 + k]) begin
            div_kind_ff[k+1] <= div_kind_ff[k];
            div_rem_ff[k+1]  <= rem_in;
            div_den_ff[k+1]  <= div_den_ff[k];
            div_quo_ff[k+1]  <= {div_quo_ff[k][14:0], fits};
         end
      end
   end

   // ---------------- hue = frac((1 - t) * scale) ----------------
   logic [16:0] norm_t;
   logic [16:0] inv_t;
   logic [32:0] hue_prod;
   logic [30:0] hue_ff;
   logic        mult_err_ff;

   always_comb begin
      case (div_kind_ff[DIV_STEPS])
         KIND_FULL:   norm_t = 17'h1_0000;
         KIND_DIVIDE: norm_t = {1'b0, div_quo_ff[DIV_STEPS]};
         default:     norm_t = 17'd0;
      endcase
   end

   assign inv_t    = 17'h1_0000 - norm_t;
   assign hue_prod = inv_t * hue_scale_ff;

   always_ff @(posedge clock) begin
      if (stage_load[STG_MULT]) begin
         hue_ff      <= hue_prod[30:0];
         mult_err_ff <= (div_kind_ff[DIV_STEPS] == KIND_RANGE_ERROR);
      end
   end

   // ---------------- hue * 6: sector and fraction ----------------
   logic [33:0] hue_six;
   logic [2:0]  sector_ff;
   logic [30:0] frac_ff;
   logic        sector_err_ff;

   assign hue_six = {1'b0, hue_ff, 2'b00} + {2'b00, hue_ff, 1'b0};

   always_ff @(posedge clock) begin
      if (stage_load[STG_SECTOR]) begin
         sector_ff     <= hue_six[33:31];
         frac_ff       <= hue_six[30:0];
         sector_err_ff <= mult_err_ff;
      end
   end

   // ---------------- ramp level, truncated to COLOR_BITS + 1 bits ----------------
   logic [31:0]         ramp_level;
   logic [COLOR_BITS:0] level_ff;
   logic [2:0]          level_sector_ff;
   logic                level_err_ff;

   // odd sectors ramp down
   assign ramp_level = sector_ff[0] ? (32'h8000_0000 - {1'b0, frac_ff}) : {1'b0, frac_ff};

   always_ff @(posedge clock) begin
      if (stage_load[STG_LEVEL]) begin
         level_ff        <= ramp_level[31 -: COLOR_BITS + 1];
         level_sector_ff <= sector_ff;
         level_err_ff    <= sector_err_ff;
      end
   end

   // ---------------- scale to 8 bits and pick channels ----------------
   logic [PW-1:0] level_wide;
   logic [PW-1:0] level_scaled;
   logic [7:0]    ramp8;
   logic [7:0]    red_in, green_in, blue_in;
   logic [7:0]    red_ff, green_ff, blue_ff;
   logic          err_ff;

   assign level_wide   = PW'(level_ff);
   assign level_scaled = (level_wide << 8) - level_wide + (PW'(1) << (COLOR_BITS - 1));
   assign ramp8        = level_scaled[COLOR_BITS + 7 : COLOR_BITS];

   always_comb begin
      red_in   = CHANNEL_ZERO;
      green_in = CHANNEL_ZERO;
      blue_in  = CHANNEL_ZERO;
      if (level_err_ff) begin
         red_in   = CHANNEL_FULL;
         green_in = CHANNEL_HALF;
         blue_in  = CHANNEL_HALF;
      end else begin
         unique case (level_sector_ff)
            SECTOR_RED_GREEN: begin
               red_in   = CHANNEL_FULL;
               green_in = ramp8;
            end
            SECTOR_GREEN_RED: begin
               red_in   = ramp8;
               green_in = CHANNEL_FULL;
            end
            SECTOR_GREEN_BLUE: begin
               green_in = CHANNEL_FULL;
               blue_in  = ramp8;
            end
            SECTOR_BLUE_GREEN: begin
               green_in = ramp8;
               blue_in  = CHANNEL_FULL;
            end
            SECTOR_BLUE_RED: begin
               red_in   = ramp8;
               blue_in  = CHANNEL_FULL;
            end
            default: begin
               red_in   = CHANNEL_FULL;
               blue_in  = ramp8;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (stage_load[STG_COLOR]) begin
         red_ff   <= red_in;
         green_ff <= green_in;
         blue_ff  <= blue_in;
         err_ff   <= level_err_ff;
      end
   end

   assign rsp_red         = red_ff;
   assign rsp_green       = green_ff;
   assign rsp_blue        = blue_ff;
   assign rsp_range_error = err_ff;

   // ---------------- assertions ----------------
   `ASSERT_CLK(a_accept_fills_front, clock, reset,
      req_valid && req_ready |=> stage_valid_ff[STG_RANGE],
      "accepted transaction did not enter the front stage")
   `ASSERT_CLK(a_sector_in_range, clock, reset,
      stage_valid_ff[STG_SECTOR] && !sector_err_ff |-> sector_ff <= SECTOR_RED_BLUE,
      "hue sector out of range")
   `ASSERT_CLK(a_error_color, clock, reset,
      rsp_valid && rsp_range_error |-> rsp_red == CHANNEL_FULL && rsp_green == CHANNEL_HALF
         && rsp_blue == CHANNEL_HALF,
      "range error without the default color")
   `ASSERT_CLK(a_hue_has_full_and_zero, clock, reset,
      rsp_valid && !rsp_range_error |->
         (rsp_red == CHANNEL_FULL || rsp_green == CHANNEL_FULL || rsp_blue == CHANNEL_FULL)
         && (rsp_red == CHANNEL_ZERO || rsp_green == CHANNEL_ZERO || rsp_blue == CHANNEL_ZERO),
      "hue color lacks a full or a zero channel")

endmodule
